// ----- hw/rtl/wsp_pkg.sv -----
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared constants for the WAVE stream parser: chunk tags, fmt body length,
// result status codes, the reset value of the sample rate register and the one-hot parser phases.
// ----------------------------------------------------------------------------
package wsp_pkg;

	// Chunk and header tags, as read little-endian into a 32-bit word
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	// Bytes of the fmt body that are parsed; a shorter fmt chunk is an error
	localparam logic [31:0] FMT_BODY_LEN = 32'd16;

	// Reset value of the expected sample rate
	localparam logic [31:0] RATE_RESET = 32'd44100;

	// Result status codes
	localparam logic [2:0] ST_SAMPLE      = 3'd0;
	localparam logic [2:0] ST_OK          = 3'd1;
	localparam logic [2:0] ST_NOT_RIFF    = 3'd2;
	localparam logic [2:0] ST_TRUNCATED   = 3'd3;
	localparam logic [2:0] ST_SHORT_FMT   = 3'd4;
	localparam logic [2:0] ST_ODD_DATA    = 3'd5;
	localparam logic [2:0] ST_UNSUPPORTED = 3'd6;
	localparam logic [2:0] ST_MISSING     = 3'd7;

	// Parser phases, one-hot
	typedef enum logic [6:0] {
		PH_RIFF   = 7'b000_0001,
		PH_HEADER = 7'b000_0010,
		PH_FMT    = 7'b000_0100,
		PH_SKIP   = 7'b000_1000,
		PH_DATA   = 7'b001_0000,
		PH_PAD    = 7'b010_0000,
		PH_IGNORE = 7'b100_0000
	} phase_t;

endpackage

// ----- hw/rtl/wav_stream_parser.sv -----
// ----------------------------------------------------------------------------
// wav_stream_parser
// Byte-wide RIFF/WAVE parser for 16-bit mono PCM: checks the header, walks
// the chunks, emits data samples and one verdict on the format.
// ----------------------------------------------------------------------------
// A result is in the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the parse state updates in the accept cycle.
// Input stalls only while the output register holds an untaken result.
// Reset (arst_n low): parser back to the RIFF header phase, all fields zero,
// expected rate 44100, output empty.
// ----------------------------------------------------------------------------
module wav_stream_parser
	import wsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration: expected sample rate
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	// input byte stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,   // end_of_stream
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] sample
	output logic [2:0]  m_axis_tuser    // [2:0] status
);

	// parse state
	phase_t      phase_q, phase_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [31:0] word_q, word_d;
	logic [31:0] len_q, len_d;
	logic        pad_q, pad_d;
	logic [15:0] format_q, format_d;
	logic [15:0] chans_q, chans_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] align_q, align_d;
	logic [15:0] bits_q, bits_d;
	logic        fmt_seen_q, fmt_seen_d;
	logic        data_seen_q, data_seen_d;
	logic [7:0]  low_q, low_d;
	logic        verdict_q, verdict_d;
	logic [31:0] exp_rate_q;

	// fmt fields with the byte on the input captured
	logic [15:0] format_c;
	logic [15:0] chans_c;
	logic [31:0] rate_c;
	logic [15:0] align_c;
	logic [15:0] bits_c;

	// output register
	logic        out_valid_q;
	logic [15:0] out_sample_q;
	logic [2:0]  out_status_q;

	// combinational result
	logic        have;
	logic [2:0]  status;
	logic [15:0] sample;
	logic [31:0] word_sh;
	logic [2:0]  judge_code;
	logic        s_fire;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign word_sh       = {s_axis_tdata, word_q[31:8]};

	// fmt body capture, little-endian per field
	always_comb begin
		format_c = format_q;
		chans_c  = chans_q;
		rate_c   = rate_q;
		align_c  = align_q;
		bits_c   = bits_q;
		if (phase_q == PH_FMT) begin
			case (cnt_q)
				4'd0:  format_c[7:0]  = s_axis_tdata;
				4'd1:  format_c[15:8] = s_axis_tdata;
				4'd2:  chans_c[7:0]   = s_axis_tdata;
				4'd3:  chans_c[15:8]  = s_axis_tdata;
				4'd4:  rate_c[7:0]    = s_axis_tdata;
				4'd5:  rate_c[15:8]   = s_axis_tdata;
				4'd6:  rate_c[23:16]  = s_axis_tdata;
				4'd7:  rate_c[31:24]  = s_axis_tdata;
				4'd12: align_c[7:0]   = s_axis_tdata;
				4'd13: align_c[15:8]  = s_axis_tdata;
				4'd14: bits_c[7:0]    = s_axis_tdata;
				4'd15: bits_c[15:8]   = s_axis_tdata;
				default: ;
			endcase
		end
	end

	// format check over the fmt fields, including the byte being captured
	assign judge_code = (format_c == 16'd1 && chans_c == 16'd1 && rate_c == exp_rate_q &&
		bits_c == 16'd16 && align_c == 16'd2) ? ST_OK : ST_UNSUPPORTED;

	// next parse state and result for the byte on the input
	always_comb begin
		phase_d     = phase_q;
		cnt_d       = cnt_q;
		word_d      = word_q;
		len_d       = len_q;
		pad_d       = pad_q;
		format_d    = format_c;
		chans_d     = chans_c;
		rate_d      = rate_c;
		align_d     = align_c;
		bits_d      = bits_c;
		fmt_seen_d  = fmt_seen_q;
		data_seen_d = data_seen_q;
		low_d       = low_q;
		verdict_d   = verdict_q;
		have        = 1'b0;
		status      = ST_SAMPLE;
		sample      = '0;

		case (phase_q)
			PH_RIFF: begin
				word_d = word_sh;
				if (cnt_q == 4'd3) len_d = word_sh;
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd11) begin
					cnt_d = '0;
					if (len_q != TAG_RIFF || word_sh != TAG_WAVE) begin
						have      = 1'b1;
						status    = ST_NOT_RIFF;
						verdict_d = 1'b1;
						phase_d   = PH_IGNORE;
					end else begin
						phase_d = PH_HEADER;
					end
				end
			end
			PH_HEADER: begin
				word_d = word_sh;
				if (cnt_q == 4'd3) len_d = word_sh;
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd7) begin
					cnt_d = '0;
					if (len_q == TAG_FMT) begin
						if (word_sh < FMT_BODY_LEN) begin
							have      = 1'b1;
							status    = ST_SHORT_FMT;
							verdict_d = 1'b1;
							phase_d   = PH_IGNORE;
						end else begin
							len_d   = word_sh - FMT_BODY_LEN;
							pad_d   = word_sh[0];
							phase_d = PH_FMT;
						end
					end else if (len_q == TAG_DATA) begin
						if (word_sh[0]) begin
							have      = 1'b1;
							status    = ST_ODD_DATA;
							verdict_d = 1'b1;
							phase_d   = PH_IGNORE;
						end else if (word_sh == '0) begin
							data_seen_d = 1'b1;
							if (fmt_seen_q) begin
								have      = 1'b1;
								status    = judge_code;
								verdict_d = 1'b1;
								phase_d   = PH_IGNORE;
							end else begin
								phase_d = pad_q ? PH_PAD : PH_HEADER;
								pad_d   = 1'b0;
							end
						end else begin
							len_d   = word_sh;
							phase_d = PH_DATA;
						end
					end else begin
						// unknown chunk: skip body and pad
						len_d = word_sh;
						if (word_sh == '0) begin
							phase_d = word_sh[0] ? PH_PAD : PH_HEADER;
							pad_d   = 1'b0;
						end else begin
							pad_d   = word_sh[0];
							phase_d = PH_SKIP;
						end
					end
				end
			end
			PH_FMT: begin
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					fmt_seen_d = 1'b1;
					cnt_d      = '0;
					if (data_seen_q) begin
						have      = 1'b1;
						status    = judge_code;
						verdict_d = 1'b1;
						phase_d   = PH_IGNORE;
					end else if (len_q != '0) begin
						phase_d = PH_SKIP;
					end else begin
						phase_d = pad_q ? PH_PAD : PH_HEADER;
						pad_d   = 1'b0;
					end
				end
			end
			PH_SKIP: begin
				len_d = len_q - 32'd1;
				if (len_q == 32'd1) begin
					phase_d = pad_q ? PH_PAD : PH_HEADER;
					pad_d   = 1'b0;
					cnt_d   = '0;
				end
			end
			PH_DATA: begin
				if (!cnt_q[0]) begin
					low_d = s_axis_tdata;
					// verdict rides on the low byte of the last sample
					if (len_q == 32'd2 && fmt_seen_q && !s_axis_tlast) begin
						have      = 1'b1;
						status    = judge_code;
						verdict_d = 1'b1;
					end
				end else begin
					have   = 1'b1;
					status = ST_SAMPLE;
					sample = {s_axis_tdata, low_q};
				end
				cnt_d = {cnt_q[3:1], ~cnt_q[0]};
				len_d = len_q - 32'd1;
				if (len_q == 32'd1) begin
					data_seen_d = 1'b1;
					if (verdict_d) begin
						phase_d = PH_IGNORE;
					end else begin
						phase_d = pad_q ? PH_PAD : PH_HEADER;
						pad_d   = 1'b0;
						cnt_d   = '0;
					end
				end
			end
			PH_PAD: begin
				phase_d = PH_HEADER;
				cnt_d   = '0;
			end
			PH_IGNORE: ;
			default: ;
		endcase

		// end of file: error if no verdict yet, then clear for the next file
		if (s_axis_tlast) begin
			if (!(have && status != ST_SAMPLE) && !verdict_d) begin
				have   = 1'b1;
				sample = '0;
				if (phase_d == PH_RIFF || phase_d == PH_FMT || phase_d == PH_DATA ||
					(phase_d == PH_HEADER && cnt_d != '0)) begin
					status = ST_TRUNCATED;
				end else begin
					status = ST_MISSING;
				end
			end
			phase_d     = PH_RIFF;
			cnt_d       = '0;
			word_d      = '0;
			len_d       = '0;
			pad_d       = 1'b0;
			format_d    = '0;
			chans_d     = '0;
			rate_d      = '0;
			align_d     = '0;
			bits_d      = '0;
			fmt_seen_d  = 1'b0;
			data_seen_d = 1'b0;
			low_d       = '0;
			verdict_d   = 1'b0;
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_RIFF;
			cnt_q       <= '0;
			word_q      <= '0;
			len_q       <= '0;
			pad_q       <= 1'b0;
			format_q    <= '0;
			chans_q     <= '0;
			rate_q      <= '0;
			align_q     <= '0;
			bits_q      <= '0;
			fmt_seen_q  <= 1'b0;
			data_seen_q <= 1'b0;
			low_q       <= '0;
			verdict_q   <= 1'b0;
		end else if (s_fire) begin
			phase_q     <= phase_d;
			cnt_q       <= cnt_d;
			word_q      <= word_d;
			len_q       <= len_d;
			pad_q       <= pad_d;
			format_q    <= format_d;
			chans_q     <= chans_d;
			rate_q      <= rate_d;
			align_q     <= align_d;
			bits_q      <= bits_d;
			fmt_seen_q  <= fmt_seen_d;
			data_seen_q <= data_seen_d;
			low_q       <= low_d;
			verdict_q   <= verdict_d;
		end
	end

	// expected rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_rate_q <= RATE_RESET;
		end else if (cfg_wr_en) begin
			exp_rate_q <= cfg_wr_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_fire) begin
			out_valid_q <= have;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire && have) begin
			out_sample_q <= sample;
			out_status_q <= status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_sample_q;
	assign m_axis_tuser  = out_status_q;

	// checks
	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && s_axis_tlast |=> phase_q == PH_RIFF && !verdict_q && !fmt_seen_q &&
			!data_seen_q && cnt_q == '0)
		else $error("state not cleared after end of file");

	a_ignore_has_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IGNORE |-> verdict_q)
		else $error("ignore phase without a verdict");

	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> len_q != '0)
		else $error("data phase with no bytes left");

	a_skip_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> len_q != '0)
		else $error("skip phase with no bytes left");

endmodule

// ----- test/wsp_checker.sv -----
// ----------------------------------------------------------------------------
// wsp_checker
// Watches both streams of the WAVE parser. Tracks the expected sample rate
// from register writes, runs its own byte-level parse of every accepted input
// item, queues the results that parse produces and compares each accepted
// output item against the oldest one, field by field.
// ----------------------------------------------------------------------------
module wsp_checker
	import wsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,   // end_of_stream
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,   // [15:0] sample
	input  logic [2:0]  m_axis_tuser,   // [2:0] status
	output int unsigned error_count,
	output int unsigned results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] pcm;
		logic [2:0]  status;
	} wav_result_t;

	// Parse state mirrored from the block
	phase_t      phase;
	logic [31:0] nbytes;
	logic [31:0] word;
	logic [31:0] chunk_len;
	logic        pad_due;
	logic [15:0] f_format;
	logic [15:0] f_channels;
	logic [31:0] f_rate;
	logic [15:0] f_align;
	logic [15:0] f_bits;
	logic        fmt_seen;
	logic        data_seen;
	logic [7:0]  low_byte;
	logic        verdict_done;
	logic [31:0] rate_cfg;

	wav_result_t parsed_q[$];

	initial error_count = 0;

	function automatic void clear_parser();
		phase = PH_RIFF;
		nbytes = '0;
		word = '0;
		chunk_len = '0;
		pad_due = 1'b0;
		f_format = '0;
		f_channels = '0;
		f_rate = '0;
		f_align = '0;
		f_bits = '0;
		fmt_seen = 1'b0;
		data_seen = 1'b0;
		low_byte = '0;
		verdict_done = 1'b0;
	endfunction

	function automatic logic [2:0] fmt_verdict();
		if (f_format == 16'd1 && f_channels == 16'd1 && f_rate == rate_cfg &&
		    f_bits == 16'd16 && f_align == 16'd2)
			return ST_OK;
		return ST_UNSUPPORTED;
	endfunction

	// next chunk header, or the pad byte first when the chunk size was odd
	function automatic void close_chunk();
		phase = pad_due ? PH_PAD : PH_HEADER;
		pad_due = 1'b0;
		nbytes = '0;
	endfunction

	// One input item through the parser; at most one result
	function automatic void parse_byte(input logic [7:0] b, input logic eos,
	                                   output logic have, output wav_result_t res);
		logic [31:0] id;
		logic [31:0] size;
		logic [3:0]  k;
		have = 1'b0;
		res.pcm = '0;
		res.status = ST_SAMPLE;
		case (phase)
			PH_RIFF: begin
				word = {b, word[31:8]};
				if (nbytes == 32'd3)
					chunk_len = word;
				nbytes = nbytes + 1;
				if (nbytes == 32'd12) begin
					nbytes = '0;
					if (chunk_len != TAG_RIFF || word != TAG_WAVE) begin
						have = 1'b1;
						res.status = ST_NOT_RIFF;
						verdict_done = 1'b1;
						phase = PH_IGNORE;
					end else begin
						phase = PH_HEADER;
					end
				end
			end
			PH_HEADER: begin
				word = {b, word[31:8]};
				if (nbytes == 32'd3)
					chunk_len = word;
				nbytes = nbytes + 1;
				if (nbytes == 32'd8) begin
					id = chunk_len;
					size = word;
					nbytes = '0;
					if (id == TAG_FMT) begin
						if (size < FMT_BODY_LEN) begin
							have = 1'b1;
							res.status = ST_SHORT_FMT;
							verdict_done = 1'b1;
							phase = PH_IGNORE;
						end else begin
							chunk_len = size - FMT_BODY_LEN;
							pad_due = size[0];
							phase = PH_FMT;
						end
					end else if (id == TAG_DATA) begin
						if (size[0]) begin
							have = 1'b1;
							res.status = ST_ODD_DATA;
							verdict_done = 1'b1;
							phase = PH_IGNORE;
						end else if (size == '0) begin
							data_seen = 1'b1;
							if (fmt_seen) begin
								have = 1'b1;
								res.status = fmt_verdict();
								verdict_done = 1'b1;
								phase = PH_IGNORE;
							end else begin
								close_chunk();
							end
						end else begin
							chunk_len = size;
							phase = PH_DATA;
						end
					end else begin
						// unknown chunk: skip body
						chunk_len = size;
						pad_due = size[0];
						if (size == '0)
							close_chunk();
						else
							phase = PH_SKIP;
					end
				end
			end
			PH_FMT: begin
				k = nbytes[3:0];
				if (k < 4'd2)
					f_format[8*k[0] +: 8] = b;
				else if (k < 4'd4)
					f_channels[8*k[0] +: 8] = b;
				else if (k < 4'd8)
					f_rate[8*k[1:0] +: 8] = b;
				else if (k >= 4'd12 && k < 4'd14)
					f_align[8*k[0] +: 8] = b;
				else if (k >= 4'd14)
					f_bits[8*k[0] +: 8] = b;
				nbytes = nbytes + 1;
				if (nbytes >= FMT_BODY_LEN) begin
					fmt_seen = 1'b1;
					nbytes = '0;
					if (data_seen) begin
						have = 1'b1;
						res.status = fmt_verdict();
						verdict_done = 1'b1;
						phase = PH_IGNORE;
					end else if (chunk_len != '0) begin
						phase = PH_SKIP;
					end else begin
						close_chunk();
					end
				end
			end
			PH_SKIP: begin
				chunk_len = chunk_len - 1;
				if (chunk_len == '0)
					close_chunk();
			end
			PH_DATA: begin
				if (!nbytes[0]) begin
					low_byte = b;
					// verdict rides on the low byte of the final sample
					if (chunk_len == 32'd2 && fmt_seen && !eos) begin
						have = 1'b1;
						res.status = fmt_verdict();
						verdict_done = 1'b1;
					end
				end else begin
					have = 1'b1;
					res.status = ST_SAMPLE;
					res.pcm = {b, low_byte};
				end
				nbytes[0] = ~nbytes[0];
				chunk_len = chunk_len - 1;
				if (chunk_len == '0) begin
					data_seen = 1'b1;
					if (verdict_done)
						phase = PH_IGNORE;
					else
						close_chunk();
				end
			end
			PH_PAD: begin
				phase = PH_HEADER;
				nbytes = '0;
			end
			default: begin
			end
		endcase

		// end of file without a verdict: truncated or missing chunk
		if (eos) begin
			if (!(have && res.status != ST_SAMPLE) && !verdict_done) begin
				if (phase == PH_RIFF || phase == PH_FMT || phase == PH_DATA)
					res.status = ST_TRUNCATED;
				else if (phase == PH_HEADER && nbytes != '0)
					res.status = ST_TRUNCATED;
				else
					res.status = ST_MISSING;
				have = 1'b1;
				res.pcm = '0;
			end
			clear_parser();
		end
	endfunction

	// Compare output items, track register writes, predict from input items
	always @(posedge clk or negedge arst_n) begin
		logic        have;
		wav_result_t res;
		wav_result_t want;
		if (!arst_n) begin
			rate_cfg = RATE_RESET;
			clear_parser();
			parsed_q.delete();
			results_due = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (parsed_q.size() == 0) begin
					$error("unexpected result: sample %0d status %0d",
					       $signed(m_axis_tdata), m_axis_tuser);
					error_count = error_count + 1;
				end else begin
					want = parsed_q.pop_front();
					if (m_axis_tdata !== want.pcm) begin
						$error("sample: expected %0d actual %0d",
						       $signed(want.pcm), $signed(m_axis_tdata));
						error_count = error_count + 1;
					end
					if (m_axis_tuser !== want.status) begin
						$error("status: expected %0d actual %0d",
						       want.status, m_axis_tuser);
						error_count = error_count + 1;
					end
				end
			end
			if (cfg_wr_en)
				rate_cfg = cfg_wr_data;
			if (s_axis_tvalid && s_axis_tready) begin
				parse_byte(s_axis_tdata, s_axis_tlast, have, res);
				if (have)
					parsed_q.push_back(res);
			end
			results_due = parsed_q.size();
		end
	end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus for the WAVE stream parser: a directed set of small files for
// each verdict, error and end-of-file case, then random files (well formed,
// cut short, broken, oversized or plain noise) across several sample rate
// settings, with random gaps and back-pressure on both streams.
// ----------------------------------------------------------------------------
module tb
	import wsp_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET    = 1600;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef enum {FILE_WAVE, FILE_CUT, FILE_BROKEN, FILE_HUGE, FILE_NOISE} file_shape_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;    // [7:0] in_byte
	logic        s_axis_tlast = 1'b0;  // end_of_stream
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;         // [15:0] sample
	logic [2:0]  m_axis_tuser;         // [2:0] status
	int unsigned error_count;
	int unsigned results_due;

	logic [7:0]  file_q[$];
	logic [31:0] rate_now = RATE_RESET;
	int          tx_gap_max = 0;
	int          rx_stall_max = 0;
	bit          rx_hold_req = 1'b0;
	int          items_sent = 0;
	int          idle_cycles = 0;

	wav_stream_parser u_dut (.*);
	wsp_checker u_checker (.*);

	always #2 clk = ~clk;

	// Watchdog: cycles with no item moving on either stream
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("FAIL wav_stream_parser");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// File building
	function automatic void put8(input logic [7:0] v);
		file_q.push_back(v);
	endfunction

	function automatic void put16(input logic [15:0] v);
		put8(v[7:0]);
		put8(v[15:8]);
	endfunction

	function automatic void put32(input logic [31:0] v);
		put16(v[15:0]);
		put16(v[31:16]);
	endfunction

	function automatic void put_random(input int n);
		repeat (n) put8(8'($urandom_range(0, 255)));
	endfunction

	function automatic void put_riff();
		put32(TAG_RIFF);
		put32($urandom);
		put32(TAG_WAVE);
	endfunction

	function automatic void put_hdr(input logic [31:0] id, input logic [31:0] size);
		put32(id);
		put32(size);
	endfunction

	function automatic void put_fmt_body(input logic [15:0] format, input logic [15:0] channels,
	                                     input logic [31:0] rate, input logic [15:0] align,
	                                     input logic [15:0] bits);
		put16(format);
		put16(channels);
		put32(rate);
		put32(rate * 2);
		put16(align);
		put16(bits);
	endfunction

	function automatic void put_good_fmt(input logic [31:0] rate);
		put_hdr(TAG_FMT, FMT_BODY_LEN);
		put_fmt_body(16'd1, 16'd1, rate, 16'd2, 16'd16);
	endfunction

	// unknown chunk, small, pad byte included when odd
	function automatic void put_other();
		int size;
		size = $urandom_range(0, 9);
		put_hdr($urandom, size);
		put_random(size + size % 2);
	endfunction

	function automatic void put_data();
		int pairs;
		pairs = $urandom_range(0, 24);
		put_hdr(TAG_DATA, 2 * pairs);
		put_random(2 * pairs);
	endfunction

	function automatic logic [15:0] mostly(input logic [15:0] v);
		return ($urandom_range(0, 9) != 0) ? v : 16'($urandom_range(0, 16'hFFFF));
	endfunction

	// Well-formed file with random content; fmt or data now and then left out
	function automatic void build_wave();
		int extra;
		bit data_first;
		data_first = ($urandom_range(0, 4) == 0);
		put_riff();
		repeat ($urandom_range(0, 2)) put_other();
		if (data_first)
			repeat ($urandom_range(1, 2)) put_data();
		if ($urandom_range(0, 19) != 0) begin
			extra = $urandom_range(0, 1) ? 0 : $urandom_range(1, 5);
			put_hdr(TAG_FMT, FMT_BODY_LEN + extra);
			put_fmt_body(mostly(16'd1), mostly(16'd1),
			             ($urandom_range(0, 9) != 0) ? rate_now : $urandom,
			             mostly(16'd2), mostly(16'd16));
			put_random(extra + extra % 2);
		end
		if ($urandom_range(0, 3) == 0)
			put_other();
		if (!data_first && $urandom_range(0, 19) != 0)
			put_data();
		put_random($urandom_range(0, 3));
	endfunction

	function automatic void build_file();
		file_shape_t shape;
		int          pct;
		int          cut;
		int          idx;
		logic [31:0] big;
		pct = $urandom_range(0, 99);
		if (pct < 70)
			shape = FILE_WAVE;
		else if (pct < 84)
			shape = FILE_CUT;
		else if (pct < 90)
			shape = FILE_BROKEN;
		else if (pct < 95)
			shape = FILE_HUGE;
		else
			shape = FILE_NOISE;
		case (shape)
			FILE_WAVE: build_wave();
			FILE_CUT: begin
				build_wave();
				cut = $urandom_range(1, file_q.size());
				while (file_q.size() > cut)
					void'(file_q.pop_back());
			end
			FILE_BROKEN: begin
				put_riff();
				case ($urandom_range(0, 2))
					0: begin
						// flip one bit of the RIFF or WAVE tag
						idx = $urandom_range(0, 7);
						if (idx > 3)
							idx = idx + 4;
						file_q[idx] = file_q[idx] ^ (8'h01 << $urandom_range(0, 7));
					end
					1: put_hdr(TAG_FMT, $urandom_range(0, 15));
					default: begin
						if ($urandom_range(0, 1))
							put_good_fmt(rate_now);
						put_hdr(TAG_DATA, $urandom | 32'h1);
					end
				endcase
				put_random($urandom_range(0, 4));
			end
			FILE_HUGE: begin
				// declared size far beyond the bytes that follow
				put_riff();
				big = $urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
				case ($urandom_range(0, 2))
					0: put_hdr($urandom, big);
					1: begin
						put_hdr(TAG_FMT, big);
						put_fmt_body(16'd1, 16'd1, rate_now, 16'd2, 16'd16);
					end
					default: begin
						if ($urandom_range(0, 1))
							put_good_fmt(rate_now);
						put_hdr(TAG_DATA, big & ~32'h1);
					end
				endcase
				put_random($urandom_range(0, 20));
			end
			default: put_random($urandom_range(1, 30));
		endcase
	endfunction

	// Sender: one file, end flag on its last item
	task automatic send_file();
		int gap;
		foreach (file_q[i]) begin
			gap = $urandom_range(0, tx_gap_max);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_axis_tdata <= file_q[i];
			s_axis_tlast <= (i == file_q.size() - 1);
			s_axis_tvalid <= 1'b1;
			@(negedge clk);
			while (!s_axis_tready) @(negedge clk);
			@(posedge clk);
		end
		items_sent += file_q.size();
		file_q.delete();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int pick_idle();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 3;
			default: return 12;
		endcase
	endfunction

	task automatic wait_idle();
		@(negedge clk);
		while (results_due != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_rate(input logic [31:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		rate_now = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Receiver: random stall per item, one long hold on request
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				stall = RX_HOLD_CYCLES;
			end else begin
				stall = $urandom_range(0, rx_stall_max);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(negedge clk);
			while (!m_axis_tvalid) @(negedge clk);
			@(posedge clk);
		end
	end

	// Stimulus
	initial begin
		logic [31:0] rate_plan [5];
		int          file_no;
		rate_plan = '{32'd1, 32'hFFFF_FFFF, 32'd8000, RATE_RESET, 32'd48000};
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed files, rate at its reset value
		// good file: extreme samples, verdict before the last one, trailing byte
		tx_gap_max = pick_idle(); rx_stall_max = pick_idle();
		put_riff(); put_good_fmt(RATE_RESET); put_hdr(TAG_DATA, 6);
		put16(16'h8000); put16(16'h7FFF); put16(16'h00FF); put8(8'hFF);
		send_file();
		// data chunks ahead of fmt, odd unknown chunk with pad, fmt with extra bytes
		put_riff(); put_hdr(TAG_DATA, 2); put_random(2);
		put_hdr(32'h5453_494C, 3); put_random(4);
		put_hdr(TAG_DATA, 4); put_random(4);
		put_hdr(TAG_FMT, 18); put_fmt_body(16'd1, 16'd1, RATE_RESET, 16'd2, 16'd16);
		put_random(4);
		send_file();
		// odd fmt size with pad, then an empty data chunk
		tx_gap_max = pick_idle(); rx_stall_max = pick_idle();
		put_riff(); put_hdr(TAG_FMT, 17); put_fmt_body(16'd1, 16'd1, RATE_RESET, 16'd2, 16'd16);
		put_random(2); put_hdr(TAG_DATA, 0);
		send_file();
		// not a RIFF file
		put32(TAG_RIFF); put32($urandom); put32(TAG_WAVE ^ 32'h0100_0000); put_random(2);
		send_file();
		// fmt too short
		put_riff(); put_hdr(TAG_FMT, 15); put_random(3);
		send_file();
		// odd data size
		put_riff(); put_good_fmt(RATE_RESET); put_hdr(TAG_DATA, 3); put_random(3);
		send_file();
		// stereo 8-bit: unsupported
		tx_gap_max = pick_idle(); rx_stall_max = pick_idle();
		put_riff(); put_hdr(TAG_FMT, 16); put_fmt_body(16'd1, 16'd2, RATE_RESET, 16'd2, 16'd8);
		put_hdr(TAG_DATA, 2); put_random(2);
		send_file();
		// rate off by one: unsupported
		put_riff(); put_hdr(TAG_FMT, 16);
		put_fmt_body(16'd1, 16'd1, RATE_RESET + 1, 16'd2, 16'd16);
		put_hdr(TAG_DATA, 4); put_random(4);
		send_file();
		// one-byte file
		put8(8'h52);
		send_file();
		// end inside a chunk header
		put_riff(); put_random(3);
		send_file();
		// end inside the fmt body
		put_riff(); put_hdr(TAG_FMT, 16); put_random(5);
		send_file();
		// end right at a chunk boundary
		tx_gap_max = pick_idle(); rx_stall_max = pick_idle();
		put_riff(); put_hdr(32'h6B6E_756A, 2); put_random(2);
		send_file();
		// end on the pad byte
		put_riff(); put_hdr(32'h6B6E_756A, 1); put_random(2);
		send_file();
		// end in the middle of a skipped chunk
		put_riff(); put_hdr(32'h6B6E_756A, 5); put_random(2);
		send_file();
		// end on the low byte of the last sample
		put_riff(); put_good_fmt(RATE_RESET); put_hdr(TAG_DATA, 4); put_random(3);
		send_file();
		// data but no fmt
		put_riff(); put_hdr(TAG_DATA, 2); put_random(2);
		send_file();

		// random files, new rate every few files
		file_no = 0;
		while (items_sent < ITEM_TARGET) begin
			if (file_no % 4 == 0) begin
				wait_idle();
				write_rate((file_no / 4 < 5) ? rate_plan[file_no / 4] : ($urandom | 32'h1));
			end
			tx_gap_max = pick_idle();
			rx_stall_max = pick_idle();
			if (file_no == 6) begin
				// long receiver hold while a long data chunk keeps coming
				rx_hold_req = 1'b1;
				tx_gap_max = 0;
				put_riff(); put_good_fmt(rate_now); put_hdr(TAG_DATA, 160); put_random(160);
			end else begin
				build_file();
			end
			send_file();
			file_no++;
		end

		wait_idle();
		if (error_count == 0 && results_due == 0)
			$display("PASS wav_stream_parser");
		else
			$display("FAIL wav_stream_parser");
		$finish;
	end

endmodule
